### hdl/rk4_second_order_lowpass_core_defines.svh
// assertion macros for the rk4 low-pass core
`ifndef RK4_SECOND_ORDER_LOWPASS_CORE_DEFINES_SVH
`define RK4_SECOND_ORDER_LOWPASS_CORE_DEFINES_SVH

`ifndef SYNTH
`define RK4LP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rk4lp same-cycle check failed");
`define RK4LP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rk4lp next-cycle check failed");
`else
`define RK4LP_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define RK4LP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### hdl/rk4lp_pkg.sv
// shared types, constants and helpers of the rk4 low-pass core
package rk4lp_pkg;

  localparam int SAMPLE_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF    = 16;

  localparam int DERIV_W = 60;
  localparam int SUM_W   = 62;
  localparam int ACC_W   = DERIV_W + 1;
  localparam int KSUM_W  = 63;
  localparam int WIDE_W  = 66;

  localparam int HALF_STEP_SHIFT = 33;
  localparam int STEP_SHIFT      = 32;
  localparam int SUM_SHIFT       = 29;

  localparam int DIV_ROUND     = 24;
  localparam int DIV_PRESHIFT  = 4;
  localparam int DIV_DIGIT_W   = 8;
  localparam int DIV_DIGITS    = 64 / DIV_DIGIT_W;
  localparam int DIV_CNT_W     = $clog2(DIV_DIGITS);
  localparam int RECIP3        = 683;
  localparam int RECIP3_SHIFT  = 11;

  localparam int CFG_IDX_W = 8;

  localparam logic [31:0] STIFFNESS_RESET = 32'd258463498;
  localparam logic [31:0] DAMPING_RESET   = 32'd5761925;
  localparam logic [31:0] GAIN_RESET      = 32'd258463498;
  localparam logic [31:0] TIME_STEP_RESET = 32'd42949673;

  typedef logic signed [63:0] s64_t;
  typedef logic signed [WIDE_W-1:0] wide_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STIFFNESS = 8'd0,
    REG_DAMPING   = 8'd1,
    REG_GAIN      = 8'd2,
    REG_TIME_STEP = 8'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    SH_FRAC,
    SH_HALF_STEP,
    SH_STEP,
    SH_SUM
  } shift_sel_t;

  typedef struct packed {
    logic       start;
    shift_sel_t shift;
    logic       wide;
  } mul_req_t;

  typedef struct packed {
    logic done;
    s64_t res;
  } mul_rsp_t;

  typedef struct packed {
    logic done;
    s64_t quot;
  } div_rsp_t;

  function automatic wide_t sat_wide(wide_t v, int unsigned w);
    wide_t hi;
    wide_t lo;
    hi = (wide_t'(1) <<< (w - 1)) - wide_t'(1);
    lo = -hi - wide_t'(1);
    if (v > hi) begin
      return hi;
    end else if (v < lo) begin
      return lo;
    end
    return v;
  endfunction

endpackage

### hdl/rk4lp_if.sv
// handshake channels of the rk4 low-pass core
interface rk4lp_in_if #(parameter int W = rk4lp_pkg::SAMPLE_WIDTH_DEF) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] sample_in;
  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface rk4lp_out_if #(parameter int W = rk4lp_pkg::SAMPLE_WIDTH_DEF) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] filtered_out;
  modport source (output valid, output filtered_out, input ready);
  modport sink (input valid, input filtered_out, output ready);
endinterface

interface rk4lp_cfg_if ();
  logic                               valid;
  logic                               ready;
  logic [rk4lp_pkg::CFG_IDX_W-1:0]    reg_index;
  logic [31:0]                        reg_data;
  modport source (output valid, output reg_index, output reg_data, input ready);
  modport sink (input valid, input reg_index, input reg_data, output ready);
endinterface

### hdl/rk4_second_order_lowpass_core.sv
// top level of the rk4 second-order low-pass core
// usage:
//   in_chan carries one sample word (signed, FRAC_BITS fraction bits) per handshake;
//   out_chan returns the new filtered position word for each sample, one for one.
//   cfg_chan writes stiffness (0), damping (1), input gain (2) and time step (3);
//   it is always ready, other indexes are dropped. write only while idle.
// sequencing:
//   a sample runs through 17 products of 64x32 bits on the single 32x32 multiplier,
//   each in steps (issue, two partial products, round and clip, apply), plus two
//   byte-serial divides by 48, four slope sums and a load of the output register.
//   in_chan.ready is high only in the idle state, so one sample is in work at a time.
// stall and reset:
//   the result sits in an output register; a new sample is taken while it waits.
//   if a second result finishes before the first is taken, the core holds in its
//   output state until out_chan.ready frees the register.
//   rst_n (synchronous, active low) clears position and rate and restores defaults.
`include "rk4_second_order_lowpass_core_defines.svh"

module rk4_second_order_lowpass_core #(
  parameter int SAMPLE_WIDTH = rk4lp_pkg::SAMPLE_WIDTH_DEF,
  parameter int FRAC_BITS    = rk4lp_pkg::FRAC_BITS_DEF
) (
  input logic          clk,
  input logic          rst_n,
  rk4lp_in_if.sink     in_chan,
  rk4lp_out_if.source  out_chan,
  rk4lp_cfg_if.sink    cfg_chan
);
  import rk4lp_pkg::*;

  localparam int RATE_W = (SAMPLE_WIDTH + 8 > 64) ? 64 : SAMPLE_WIDTH + 8;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_ISSUE = 7'b0000010,
    S_WAIT  = 7'b0000100,
    S_SUM   = 7'b0001000,
    S_DIV   = 7'b0010000,
    S_DWAIT = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  typedef enum logic [2:0] {
    OP_G,
    OP_STIFF,
    OP_DAMP,
    OP_KP,
    OP_KR,
    OP_SP,
    OP_SR
  } op_t;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;
  logic [1:0] st_r, st_nxt;

  logic [31:0] stiff_r, stiff_nxt;
  logic [31:0] damp_r, damp_nxt;
  logic [31:0] gain_r, gain_nxt;
  logic [31:0] ts_r, ts_nxt;

  logic signed [SAMPLE_WIDTH-1:0] p_r, p_nxt;
  logic signed [RATE_W-1:0]       r_r, r_nxt;
  logic signed [SAMPLE_WIDTH-1:0] u_r, u_nxt;
  logic signed [SAMPLE_WIDTH-1:0] ps_r, ps_nxt;
  logic signed [RATE_W-1:0]       rs_r, rs_nxt;
  logic signed [DERIV_W-1:0]      g_r, g_nxt;
  logic signed [ACC_W-1:0]        acc_r, acc_nxt;
  logic signed [DERIV_W-1:0]      kp_r, kp_nxt;
  logic signed [DERIV_W-1:0]      kr_r, kr_nxt;
  logic signed [KSUM_W-1:0]       sp_r, sp_nxt;
  logic signed [KSUM_W-1:0]       sr_r, sr_nxt;

  logic                           out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_WIDTH-1:0] out_data_r, out_data_nxt;

  mul_req_t    mul_req;
  mul_rsp_t    mul_rsp;
  s64_t        mul_a;
  logic [31:0] mul_b;
  div_rsp_t    div_rsp;
  logic        div_start;

  logic                     dbl_weight;
  logic signed [KSUM_W-1:0] kp_term;
  logic signed [KSUM_W-1:0] kr_term;

  rk4lp_mulsh #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mulsh (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .a     (mul_a),
    .b     (mul_b),
    .rsp   (mul_rsp)
  );

  rk4lp_div48 u_div48 (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .value (mul_rsp.res),
    .rsp   (div_rsp)
  );

  assign in_chan.ready         = (state_r == S_IDLE);
  assign cfg_chan.ready        = 1'b1;
  assign out_chan.valid        = out_valid_r;
  assign out_chan.filtered_out = out_data_r;
  assign div_start             = (state_r == S_DIV);

  // operand and format select for the shared multiplier
  always_comb begin
    mul_req.start = (state_r == S_ISSUE);
    mul_req.wide  = 1'b0;
    mul_req.shift = SH_FRAC;
    case (op_r)
      OP_G: begin
        mul_a = s64_t'(u_r);
        mul_b = gain_r;
      end
      OP_STIFF: begin
        mul_a = s64_t'(ps_r);
        mul_b = stiff_r;
      end
      OP_DAMP: begin
        mul_a = s64_t'(rs_r);
        mul_b = damp_r;
      end
      OP_KP: begin
        mul_a         = s64_t'(kp_r);
        mul_b         = ts_r;
        mul_req.shift = (st_r == 2'd2) ? SH_STEP : SH_HALF_STEP;
      end
      OP_KR: begin
        mul_a         = s64_t'(kr_r);
        mul_b         = ts_r;
        mul_req.shift = (st_r == 2'd2) ? SH_STEP : SH_HALF_STEP;
      end
      OP_SP: begin
        mul_a         = s64_t'(sp_r);
        mul_b         = ts_r;
        mul_req.shift = SH_SUM;
        mul_req.wide  = 1'b1;
      end
      OP_SR: begin
        mul_a         = s64_t'(sr_r);
        mul_b         = ts_r;
        mul_req.shift = SH_SUM;
        mul_req.wide  = 1'b1;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign dbl_weight = st_r inside {2'd1, 2'd2};
  assign kp_term    = dbl_weight ? (KSUM_W'(kp_r) <<< 1) : KSUM_W'(kp_r);
  assign kr_term    = dbl_weight ? (KSUM_W'(kr_r) <<< 1) : KSUM_W'(kr_r);

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    st_nxt        = st_r;
    stiff_nxt     = stiff_r;
    damp_nxt      = damp_r;
    gain_nxt      = gain_r;
    ts_nxt        = ts_r;
    p_nxt         = p_r;
    r_nxt         = r_r;
    u_nxt         = u_r;
    ps_nxt        = ps_r;
    rs_nxt        = rs_r;
    g_nxt         = g_r;
    acc_nxt       = acc_r;
    kp_nxt        = kp_r;
    kr_nxt        = kr_r;
    sp_nxt        = sp_r;
    sr_nxt        = sr_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (cfg_chan.valid) begin
      case (cfg_chan.reg_index)
        REG_STIFFNESS: stiff_nxt = cfg_chan.reg_data;
        REG_DAMPING:   damp_nxt  = cfg_chan.reg_data;
        REG_GAIN:      gain_nxt  = cfg_chan.reg_data;
        REG_TIME_STEP: ts_nxt    = cfg_chan.reg_data;
        default: ;
      endcase
    end

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          u_nxt     = SAMPLE_WIDTH'(in_chan.sample_in);
          ps_nxt    = p_r;
          rs_nxt    = r_r;
          sp_nxt    = '0;
          sr_nxt    = '0;
          st_nxt    = '0;
          op_nxt    = OP_G;
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: begin
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (mul_rsp.done) begin
          state_nxt = S_ISSUE;
          case (op_r)
            OP_G: begin
              g_nxt  = DERIV_W'(mul_rsp.res);
              op_nxt = OP_STIFF;
            end
            OP_STIFF: begin
              acc_nxt = ACC_W'(g_r) - ACC_W'(mul_rsp.res);
              op_nxt  = OP_DAMP;
            end
            OP_DAMP: begin
              kr_nxt    = DERIV_W'(sat_wide(wide_t'(acc_r) - wide_t'(mul_rsp.res), DERIV_W));
              kp_nxt    = DERIV_W'(sat_wide(wide_t'(rs_r), DERIV_W));
              state_nxt = S_SUM;
            end
            OP_KP: begin
              ps_nxt = SAMPLE_WIDTH'(sat_wide(wide_t'(p_r) + wide_t'(mul_rsp.res),
                                              SAMPLE_WIDTH));
              op_nxt = OP_KR;
            end
            OP_KR: begin
              rs_nxt = RATE_W'(sat_wide(wide_t'(r_r) + wide_t'(mul_rsp.res), RATE_W));
              st_nxt = st_r + 2'd1;
              op_nxt = OP_STIFF;
            end
            OP_SP, OP_SR: begin
              state_nxt = S_DIV;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_SUM: begin
        sp_nxt    = sp_r + kp_term;
        sr_nxt    = sr_r + kr_term;
        op_nxt    = (st_r == 2'd3) ? OP_SP : OP_KP;
        state_nxt = S_ISSUE;
      end
      S_DIV: begin
        state_nxt = S_DWAIT;
      end
      S_DWAIT: begin
        if (div_rsp.done) begin
          if (op_r == OP_SP) begin
            p_nxt     = SAMPLE_WIDTH'(sat_wide(wide_t'(p_r) + wide_t'(div_rsp.quot),
                                               SAMPLE_WIDTH));
            op_nxt    = OP_SR;
            state_nxt = S_ISSUE;
          end else begin
            r_nxt     = RATE_W'(sat_wide(wide_t'(r_r) + wide_t'(div_rsp.quot), RATE_W));
            state_nxt = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = p_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_G;
      st_r        <= '0;
      stiff_r     <= STIFFNESS_RESET;
      damp_r      <= DAMPING_RESET;
      gain_r      <= GAIN_RESET;
      ts_r        <= TIME_STEP_RESET;
      p_r         <= '0;
      r_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      st_r        <= st_nxt;
      stiff_r     <= stiff_nxt;
      damp_r      <= damp_nxt;
      gain_r      <= gain_nxt;
      ts_r        <= ts_nxt;
      p_r         <= p_nxt;
      r_r         <= r_nxt;
      out_valid_r <= out_valid_nxt;
    end
    u_r        <= u_nxt;
    ps_r       <= ps_nxt;
    rs_r       <= rs_nxt;
    g_r        <= g_nxt;
    acc_r      <= acc_nxt;
    kp_r       <= kp_nxt;
    kr_r       <= kr_nxt;
    sp_r       <= sp_nxt;
    sr_r       <= sr_nxt;
    out_data_r <= out_data_nxt;
  end

  `RK4LP_ASSERT_NEXT(a_accept_starts, clk, rst_n, in_chan.valid && in_chan.ready, state_r == S_ISSUE && op_r == OP_G)
  `RK4LP_ASSERT_SAME(a_mul_done_waiting, clk, rst_n, mul_rsp.done, state_r == S_WAIT)
  `RK4LP_ASSERT_SAME(a_div_done_waiting, clk, rst_n, div_rsp.done, state_r == S_DWAIT)
  `RK4LP_ASSERT_NEXT(a_out_load, clk, rst_n, state_r == S_OUT && (!out_valid_r || out_chan.ready), out_chan.valid && out_chan.filtered_out == $past(p_r))

endmodule

### hdl/rk4lp_mulsh.sv
// shared 64x32 multiply with rounding shift and saturation, two partial products
module rk4lp_mulsh #(
  parameter int FRAC_BITS = rk4lp_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rk4lp_pkg::mul_req_t req,
  input  rk4lp_pkg::s64_t     a,
  input  logic [31:0]         b,
  output rk4lp_pkg::mul_rsp_t rsp
);
  import rk4lp_pkg::*;

  typedef enum logic [3:0] {
    P_IDLE = 4'b0001,
    P_LO   = 4'b0010,
    P_HI   = 4'b0100,
    P_FIN  = 4'b1000
  } phase_t;

  localparam logic [63:0] LIM_D = (64'd1 << (DERIV_W - 1)) - 64'd1;
  localparam logic [63:0] LIM_S = (64'd1 << (SUM_W - 1)) - 64'd1;

  phase_t     ph_r, ph_nxt;
  logic [96:0] acc_r, acc_nxt;
  logic [63:0] mag_r, mag_nxt;
  logic [31:0] b_r, b_nxt;
  logic        neg_r, neg_nxt;
  logic        wide_r, wide_nxt;
  shift_sel_t  sh_r, sh_nxt;
  logic        done_r, done_nxt;
  s64_t        res_r, res_nxt;

  logic [31:0] mul_op;
  logic [63:0] prod;
  logic [96:0] half;
  logic [96:0] shifted;
  logic [63:0] rmag;
  logic [63:0] lim;
  logic [63:0] clip;

  assign mul_op = (ph_r == P_HI) ? mag_r[63:32] : mag_r[31:0];
  assign prod   = mul_op * b_r;

  always_comb begin
    case (sh_r)
      SH_FRAC: begin
        half    = 97'd1 << (FRAC_BITS - 1);
        shifted = acc_r >> FRAC_BITS;
      end
      SH_HALF_STEP: begin
        half    = 97'd1 << (HALF_STEP_SHIFT - 1);
        shifted = acc_r >> HALF_STEP_SHIFT;
      end
      SH_STEP: begin
        half    = 97'd1 << (STEP_SHIFT - 1);
        shifted = acc_r >> STEP_SHIFT;
      end
      SH_SUM: begin
        half    = 97'd1 << (SUM_SHIFT - 1);
        shifted = acc_r >> SUM_SHIFT;
      end
      default: begin
        half    = '0;
        shifted = '0;
      end
    endcase
  end

  always_comb begin
    rmag = (|shifted[96:64]) ? '1 : shifted[63:0];
    lim  = wide_r ? LIM_S : LIM_D;
    if (!neg_r) begin
      clip = (rmag > lim) ? lim : rmag;
    end else begin
      clip = (rmag > lim + 64'd1) ? lim + 64'd1 : rmag;
    end
  end

  always_comb begin
    ph_nxt   = ph_r;
    acc_nxt  = acc_r;
    mag_nxt  = mag_r;
    b_nxt    = b_r;
    neg_nxt  = neg_r;
    wide_nxt = wide_r;
    sh_nxt   = sh_r;
    done_nxt = 1'b0;
    res_nxt  = res_r;
    case (ph_r)
      P_IDLE: begin
        if (req.start) begin
          neg_nxt  = a[63];
          mag_nxt  = a[63] ? (64'd0 - 64'(a)) : 64'(a);
          b_nxt    = b;
          sh_nxt   = req.shift;
          wide_nxt = req.wide;
          ph_nxt   = P_LO;
        end
      end
      P_LO: begin
        acc_nxt = 97'(prod) + half;
        ph_nxt  = P_HI;
      end
      P_HI: begin
        acc_nxt = acc_r + (97'(prod) << 32);
        ph_nxt  = P_FIN;
      end
      P_FIN: begin
        res_nxt  = neg_r ? s64_t'(64'd0 - clip) : s64_t'(clip);
        done_nxt = 1'b1;
        ph_nxt   = P_IDLE;
      end
      default: begin
        ph_nxt = P_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= P_IDLE;
      done_r <= 1'b0;
    end else begin
      ph_r   <= ph_nxt;
      done_r <= done_nxt;
    end
    acc_r  <= acc_nxt;
    mag_r  <= mag_nxt;
    b_r    <= b_nxt;
    neg_r  <= neg_nxt;
    wide_r <= wide_nxt;
    sh_r   <= sh_nxt;
    res_r  <= res_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.res  = res_r;

endmodule

### hdl/rk4lp_div48.sv
// rounded signed divide by 48, one byte digit per cycle
module rk4lp_div48 (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  rk4lp_pkg::s64_t     value,
  output rk4lp_pkg::div_rsp_t rsp
);
  import rk4lp_pkg::*;

  typedef enum logic [2:0] {
    D_IDLE = 3'b001,
    D_RUN  = 3'b010,
    D_FIN  = 3'b100
  } dphase_t;

  dphase_t              ph_r, ph_nxt;
  logic                 neg_r, neg_nxt;
  logic [63:0]          x_r, x_nxt;
  logic [63:0]          quo_r, quo_nxt;
  logic [1:0]           rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 done_r, done_nxt;
  s64_t                 res_r, res_nxt;

  logic [63:0]                mag;
  logic [DIV_DIGIT_W+1:0]     digit;
  logic [2*DIV_DIGIT_W+3:0]   recip_prod;
  logic [DIV_DIGIT_W-1:0]     qd;
  logic [DIV_DIGIT_W+1:0]     rem_full;

  assign mag        = value[63] ? (64'd0 - 64'(value)) : 64'(value);
  assign digit      = {rem_r, x_r[63 -: DIV_DIGIT_W]};
  assign recip_prod = (2 * DIV_DIGIT_W + 4)'(digit) * (2 * DIV_DIGIT_W + 4)'(RECIP3);
  assign qd         = recip_prod[RECIP3_SHIFT +: DIV_DIGIT_W];
  assign rem_full   = digit - (DIV_DIGIT_W + 2)'(qd) * (DIV_DIGIT_W + 2)'(3);

  always_comb begin
    ph_nxt   = ph_r;
    neg_nxt  = neg_r;
    x_nxt    = x_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    res_nxt  = res_r;
    case (ph_r)
      D_IDLE: begin
        if (start) begin
          neg_nxt = value[63];
          x_nxt   = (mag + 64'(DIV_ROUND)) >> DIV_PRESHIFT;
          quo_nxt = '0;
          rem_nxt = '0;
          cnt_nxt = '0;
          ph_nxt  = D_RUN;
        end
      end
      D_RUN: begin
        quo_nxt = {quo_r[63-DIV_DIGIT_W:0], qd};
        rem_nxt = rem_full[1:0];
        x_nxt   = x_r << DIV_DIGIT_W;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_DIGITS - 1)) begin
          ph_nxt = D_FIN;
        end
      end
      D_FIN: begin
        res_nxt  = neg_r ? s64_t'(64'd0 - quo_r) : s64_t'(quo_r);
        done_nxt = 1'b1;
        ph_nxt   = D_IDLE;
      end
      default: begin
        ph_nxt = D_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= D_IDLE;
      done_r <= 1'b0;
    end else begin
      ph_r   <= ph_nxt;
      done_r <= done_nxt;
    end
    neg_r <= neg_nxt;
    x_r   <= x_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    res_r <= res_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = res_r;

endmodule
